FILE: src/s2fss_pkg.sv
// Package for the symmetric-to-full sparse scatter unit.
// Holds the sizing constants, the request, result, configuration and control types.
// No dependencies.
`timescale 1ns / 1ps

package s2fss_pkg;

  // Sizing of the slot store and the output arrays
  localparam int MaxDim      = 1024;
  localparam int OutCapacity = 65536;
  localparam int IdxW        = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int SlotW       = (OutCapacity > 1) ? $clog2(OutCapacity) : 1;

  // Fixed field widths
  localparam int FieldIdxW = 10;
  localparam int PosW      = 16;
  localparam int ValW      = 64;
  localparam int CfgIdxW   = 2;

  localparam logic [ValW-1:0] SignMask = {1'b1, {(ValW-1){1'b0}}};

  // Operation codes
  localparam logic OpLoad  = 1'b0;
  localparam logic OpEntry = 1'b1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgUpperStored    = 2'd0,
    CfgKeepDiagonal   = 2'd1,
    CfgConjugateMirror = 2'd2
  } cfg_idx_e;

  // One input request
  typedef struct packed {
    logic                 operation;
    logic [FieldIdxW-1:0] column;
    logic [FieldIdxW-1:0] row;
    logic [PosW-1:0]      start_position;
    logic [ValW-1:0]      value_re;
    logic [ValW-1:0]      value_im;
  } req_t;

  // One result write
  typedef struct packed {
    logic [PosW-1:0]      write_position;
    logic [FieldIdxW-1:0] out_row;
    logic [ValW-1:0]      out_value_re;
    logic [ValW-1:0]      out_value_im;
    logic                 last_of_item;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;        // capture the incoming request
    logic load_wr;      // write start slot of the request column
    logic rd_row;       // slot read address: 0 column, 1 row
    logic emit_first;   // own-column write, advance column slot
    logic emit_second;  // mirrored write, advance row slot
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_load;
    logic discard;      // out of range, unstored half or dropped diagonal
    logic diag;
  } status_t;

endpackage

FILE: src/s2fss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module s2fss_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/s2fss_ctrl.sv
// Sequencing state machine of the scatter unit.
// Depends on s2fss_pkg for the control and status types.
`timescale 1ns / 1ps

module s2fss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  s2fss_pkg::status_t status_i,
  output s2fss_pkg::ctrl_t   cmd_o,
  output logic              res_valid_o
);
  import s2fss_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StDecide = 4'b0010,
    StFirst  = 4'b0100,
    StSecond = 4'b1000
  } state_e;

  state_e state_q, state_d;
  ctrl_t  cmd;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd.latch = 1'b1;
          state_d   = StDecide;
        end
      end
      StDecide: begin
        if (status_i.is_load) begin
          cmd.load_wr = 1'b1;
          state_d     = StIdle;
        end else if (status_i.discard) begin
          state_d = StIdle;
        end else begin
          cmd.rd_row = 1'b0;   // fetch column slot
          state_d    = StFirst;
        end
      end
      StFirst: begin
        cmd.emit_first = 1'b1;
        if (status_i.diag) begin
          state_d = StIdle;
        end else begin
          cmd.rd_row = 1'b1;   // fetch row slot for the mirror
          state_d    = StSecond;
        end
      end
      StSecond: begin
        cmd.emit_second = 1'b1;
        state_d         = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign cmd_o       = cmd;
  assign res_valid_o = cmd.emit_first | cmd.emit_second;

  // An accepted request always goes to decode next
  a_accept_decode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> state_q == StDecide)
    else $error("accepted request did not enter decode");

  // The mirrored write only follows the own-column write
  a_second_after_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSecond |-> $past(state_q) == StFirst)
    else $error("mirror write without preceding own-column write");

  // The own-column write only follows decode, whose read it consumes
  a_first_after_decide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFirst |-> $past(state_q) == StDecide)
    else $error("own-column write without slot fetch");

  // Never two writes in one cycle
  a_one_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.emit_first && cmd.emit_second))
    else $error("two result writes in one cycle");

endmodule

FILE: src/s2fss_dpath.sv
// Datapath of the scatter unit: request register, configuration, slot store and results.
// Depends on s2fss_pkg and s2fss_ram.
`timescale 1ns / 1ps

module s2fss_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  s2fss_pkg::req_t                     req_i,
  input  s2fss_pkg::ctrl_t                    cmd_i,
  output s2fss_pkg::status_t                  status_o,
  output s2fss_pkg::res_t                     res_o,
  input  logic                                cfg_valid_i,
  input  logic [s2fss_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic                                cfg_data_i
);
  import s2fss_pkg::*;

  req_t item_q;
  logic upper_q, diag_en_q, conj_q;

  logic             in_range, unstored, diag;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr, ram_raddr, col_addr, row_addr;
  logic [SlotW-1:0] ram_wdata, slot, slot_adv, start_slot;
  logic [SlotW-1:0] ram_rdata;

  // Request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= req_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= 1'b1;
      diag_en_q <= 1'b1;
      conj_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgUpperStored:     upper_q   <= cfg_data_i;
        CfgKeepDiagonal:    diag_en_q <= cfg_data_i;
        CfgConjugateMirror: conj_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classification of the held request
  assign in_range = (int'(item_q.column) < MaxDim) && (int'(item_q.row) < MaxDim);
  assign unstored = upper_q ? (item_q.row > item_q.column) : (item_q.row < item_q.column);
  assign diag     = (item_q.row == item_q.column);

  assign status_o.is_load = (item_q.operation == OpLoad);
  assign status_o.discard = !in_range || unstored || (diag && !diag_en_q);
  assign status_o.diag    = diag;

  // Slot arithmetic: wrap at the output capacity
  assign col_addr   = IdxW'(item_q.column);
  assign row_addr   = IdxW'(item_q.row);
  assign slot       = ram_rdata;
  assign slot_adv   = (slot == SlotW'(OutCapacity - 1)) ? '0 : slot + SlotW'(1);
  assign start_slot = SlotW'(item_q.start_position % OutCapacity);

  // Store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col_addr;
    ram_wdata = slot_adv;
    if (cmd_i.load_wr) begin
      ram_we    = (int'(item_q.column) < MaxDim);
      ram_wdata = start_slot;
    end else if (cmd_i.emit_first) begin
      ram_we = 1'b1;
    end else if (cmd_i.emit_second) begin
      ram_we    = 1'b1;
      ram_waddr = row_addr;
    end
  end

  assign ram_raddr = cmd_i.rd_row ? row_addr : col_addr;

  s2fss_ram #(
    .Width (SlotW),
    .Depth (MaxDim)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result fields: own column first, then the mirrored copy
  always_comb begin
    res_o.write_position = PosW'(slot);
    res_o.out_value_re   = item_q.value_re;
    if (cmd_i.emit_second) begin
      res_o.out_row      = item_q.column;
      res_o.out_value_im = conj_q ? (item_q.value_im ^ SignMask) : item_q.value_im;
      res_o.last_of_item = 1'b1;
    end else begin
      res_o.out_row      = item_q.row;
      res_o.out_value_im = item_q.value_im;
      res_o.last_of_item = diag;
    end
  end

endmodule

FILE: src/symmetric_to_full_sparse_scatter_unit.sv
// Top level of the symmetric-to-full sparse scatter unit.
// Depends on s2fss_pkg, s2fss_ctrl and s2fss_dpath.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------
//  request  | start_i in, busy_o out    | req_i   (s2fss_pkg::req_t)
//  result   | res_valid_o strobe out    | res_o   (s2fss_pkg::res_t)
//  config   | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A request is taken when start_i is high and busy_o low. busy_o then stays high
// through decode; for a kept diagonal also through the own-column write, for an
// off-diagonal entry through both writes. The single read port of the slot store
// sets the pace, one slot fetch per write. Each result is shown for one cycle only.
// The slot store is not cleared at reset; a column must be loaded before use.
`timescale 1ns / 1ps

module symmetric_to_full_sparse_scatter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  s2fss_pkg::req_t               req_i,
  output logic                          res_valid_o,
  output s2fss_pkg::res_t               res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [s2fss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic                          cfg_data_i
);
  import s2fss_pkg::*;

  ctrl_t   cmd;
  status_t status;
  logic    busy;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  s2fss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i && !busy),
    .busy_o      (busy),
    .status_i    (status),
    .cmd_o       (cmd),
    .res_valid_o (res_valid_o)
  );

  s2fss_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  assign busy_o = busy;

endmodule
